// ===== hw/rtl/i2s_receive_deserializer_core_defines.svh =====
// assertion helpers for the i2s receive deserializer
`ifndef I2S_RECEIVE_DESERIALIZER_CORE_DEFINES_SVH
`define I2S_RECEIVE_DESERIALIZER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2SRX_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define I2SRX_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/i2srx_pkg.sv =====
`default_nettype none

package i2srx_pkg;

  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned WIDTH_W     = 6;
  localparam int unsigned DELAY_W     = 4;
  localparam int unsigned DELAY_CNT_W = 5;
  localparam int unsigned BIT_POS_W   = 5;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 6;

  localparam logic [WIDTH_W-1:0] MAX_WIDTH     = 6'd32;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH   = 6'd16;
  localparam logic [DELAY_W-1:0] RESET_DELAY   = 4'd1;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WORD_WIDTH   = 2'd0,
    CFG_SELECT_DELAY = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/i2srx_in_if.sv =====
`default_nettype none

interface i2srx_in_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic word_select;
  logic data_bit;

  modport source (output valid, output clock_level, output word_select, output data_bit,
                  input ready);
  modport sink   (input valid, input clock_level, input word_select, input data_bit,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2srx_out_if.sv =====
`default_nettype none

interface i2srx_out_if;
  logic                             valid;
  logic                             ready;
  logic [i2srx_pkg::SAMPLE_W-1:0]   sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/i2s_receive_deserializer_core.sv =====
// channel   dir  payload                                  transfer when
// edges     in   clock_level, word_select, data_bit       valid & ready
// samples   out  sample_value[31:0]                       valid & ready
// cfg       in   cfg_index[1:0], cfg_data[5:0]            cfg_write
//
// one serial-clock edge per cycle; its state update is done in the accept cycle
// a finished sample sits in the output register, visible the cycle after its edge
// edges are taken whenever the output register is empty or is being drained
// rst is synchronous: width 16, delay 1, channel inactive, no pending sample
`default_nettype none

`include "i2s_receive_deserializer_core_defines.svh"

module i2s_receive_deserializer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  i2srx_in_if.sink                              edges,
  i2srx_out_if.source                           samples,
  input  wire logic                             cfg_write,
  input  wire logic [i2srx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [i2srx_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic [i2srx_pkg::WIDTH_W-1:0]     word_width;
  logic [i2srx_pkg::DELAY_W-1:0]     select_delay;

  // receive state
  logic                              last_select;
  logic [i2srx_pkg::DELAY_CNT_W-1:0] delay_left;
  logic                              channel_active;
  logic [i2srx_pkg::WIDTH_W-1:0]     bits_left;
  logic [i2srx_pkg::SAMPLE_W-1:0]    sample_accum;

  // output register
  logic                              out_valid;
  logic [i2srx_pkg::SAMPLE_W-1:0]    out_sample;

  logic                              last_select_next;
  logic [i2srx_pkg::DELAY_CNT_W-1:0] delay_left_next;
  logic                              channel_active_next;
  logic [i2srx_pkg::WIDTH_W-1:0]     bits_left_next;
  logic [i2srx_pkg::SAMPLE_W-1:0]    sample_accum_next;
  logic                              out_valid_next;

  logic                              accept;
  logic                              emit;
  logic [i2srx_pkg::WIDTH_W-1:0]     eff_width;
  logic [i2srx_pkg::DELAY_CNT_W-1:0] delay_start;
  logic [i2srx_pkg::BIT_POS_W-1:0]   bit_pos;
  logic [i2srx_pkg::SAMPLE_W-1:0]    accum_with_bit;

  // the slot is free, or it empties in this same cycle
  assign edges.ready          = !out_valid || samples.ready;
  assign accept               = edges.valid && edges.ready;
  assign samples.valid        = out_valid;
  assign samples.sample_value = out_sample;

  // widths above 32 act as 32
  assign eff_width = (word_width > i2srx_pkg::MAX_WIDTH) ? i2srx_pkg::MAX_WIDTH : word_width;

  // a word select rise loads delay + 1, counted down on that same edge
  assign delay_start = {1'b0, select_delay} + i2srx_pkg::DELAY_CNT_W'(1);

  // msb first: bit goes to position bits_left - 1
  assign bit_pos        = i2srx_pkg::BIT_POS_W'(bits_left - i2srx_pkg::WIDTH_W'(1));
  assign accum_with_bit = sample_accum
                        | (i2srx_pkg::SAMPLE_W'(edges.data_bit) << bit_pos);

  always_comb begin
    logic [i2srx_pkg::DELAY_CNT_W-1:0] dl;
    last_select_next    = last_select;
    delay_left_next     = delay_left;
    channel_active_next = channel_active;
    bits_left_next      = bits_left;
    sample_accum_next   = sample_accum;
    emit                = 1'b0;
    dl                  = delay_left;

    if (accept) begin
      if (edges.clock_level) begin
        // rising edge: shift in one data bit while a sample is pending
        if (channel_active && (bits_left != '0)) begin
          if (bits_left == i2srx_pkg::WIDTH_W'(1)) begin
            // last bit: hand off and rearm with a cleared accumulator
            emit              = 1'b1;
            bits_left_next    = eff_width;
            sample_accum_next = '0;
          end else begin
            bits_left_next    = bits_left - i2srx_pkg::WIDTH_W'(1);
            sample_accum_next = accum_with_bit;
          end
        end
      end else begin
        // falling edge: word select tracking and start delay
        if (edges.word_select && !last_select) begin
          dl = delay_start;
        end
        if (dl != '0) begin
          dl = dl - i2srx_pkg::DELAY_CNT_W'(1);
          if (dl == '0) begin
            // new sample starts; any partial sample is dropped
            channel_active_next = 1'b1;
            bits_left_next      = eff_width;
            sample_accum_next   = '0;
          end
        end
        delay_left_next  = dl;
        last_select_next = edges.word_select;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (samples.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_width     <= i2srx_pkg::RESET_WIDTH;
      select_delay   <= i2srx_pkg::RESET_DELAY;
      last_select    <= 1'b0;
      delay_left     <= '0;
      channel_active <= 1'b0;
      bits_left      <= '0;
      sample_accum   <= '0;
      out_valid      <= 1'b0;
    end else begin
      last_select    <= last_select_next;
      delay_left     <= delay_left_next;
      channel_active <= channel_active_next;
      bits_left      <= bits_left_next;
      sample_accum   <= sample_accum_next;
      out_valid      <= out_valid_next;
      if (cfg_write) begin
        unique case (cfg_index)
          i2srx_pkg::CFG_WORD_WIDTH:   word_width   <= cfg_data;
          i2srx_pkg::CFG_SELECT_DELAY: select_delay <= cfg_data[i2srx_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // sample payload, loaded only on the completing bit
  always_ff @(posedge clk) begin
    if (emit) begin
      out_sample <= accum_with_bit;
    end
  end

  `I2SRX_ASSERT_NOW(a_bits_in_range, 1'b1, bits_left <= i2srx_pkg::MAX_WIDTH, "bits_left above 32")
  `I2SRX_ASSERT_NOW(a_delay_in_range, 1'b1, delay_left <= 5'd16, "delay_left above 16")
  `I2SRX_ASSERT_NOW(a_idle_clean, !channel_active, (bits_left == '0) && (sample_accum == '0),
                    "pending sample state while channel inactive")
  `I2SRX_ASSERT_NEXT(a_emit_from_rise, !out_valid || samples.ready,
                     !out_valid || ($past(accept) && $past(edges.clock_level)),
                     "sample shown without a rising edge transfer")
  `I2SRX_ASSERT_NOW(a_stall_only_full, !edges.ready, out_valid && !samples.ready,
                    "edges stalled while output slot free")

endmodule

`default_nettype wire
